>>> design/npt_pkg.sv
// Shared types and constants for the nearest-point table.
// No dependencies; imported by every module of the block.
package npt_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_COORD_WIDTH = 16;
  localparam int DEF_ID_WIDTH    = 16;

  // Fixed port field widths
  localparam int OPCODE_W = 3;
  localparam int PID_W    = 16;
  localparam int PCOORD_W = 16;
  localparam int DIR_W    = 2;
  localparam int STATUS_W = 3;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POSITION = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PROBE    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_NEAREST  = 3'd4;

  // Search directions
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // One result as it leaves the sequencer
  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic [PID_W-1:0]           result_id;
    logic signed [PCOORD_W-1:0] result_x;
    logic signed [PCOORD_W-1:0] result_y;
  } npt_result_t;

endpackage

>>> design/axis_nearest_point_table.sv
// Nearest-point table top level. Every request sweeps all TABLE_DEPTH memory entries
// (one read a cycle); the result register loads in S_FINISH once the sweep has ended.
// A new request is accepted only after the previous result has moved to the output
// register; nearest adds a second sweep. After reset a clearing pass writes every entry
// invalid while in_stall stays high. Depends on npt_pkg, npt_mem, npt_ctrl.
module axis_nearest_point_table
  import npt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic [PID_W-1:0]           point_id,
  input  logic signed [PCOORD_W-1:0] x_coord,
  input  logic signed [PCOORD_W-1:0] y_coord,
  input  logic [DIR_W-1:0]           direction,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic                       found,
  output logic [PID_W-1:0]           result_id,
  output logic signed [PCOORD_W-1:0] result_x,
  output logic signed [PCOORD_W-1:0] result_y
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = 1 + ID_WIDTH + 2 * COORD_WIDTH;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;

  logic        res_valid;
  logic        res_take;
  npt_result_t res;
  npt_result_t out_q;

  npt_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  npt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .point_id    (point_id),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .direction   (direction),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
      out_q     <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status    = out_q.status;
  assign found     = out_q.found;
  assign result_id = out_q.result_id;
  assign result_x  = out_q.result_x;
  assign result_y  = out_q.result_y;

endmodule

>>> design/npt_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
// Depends on npt_pkg for the default parameter sizes.
module npt_mem
  import npt_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  parameter int WIDTH = 1 + DEF_ID_WIDTH + 2 * DEF_COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/npt_ctrl.sv
// Request sequencer: scans the table memory, keeps matches and the best
// neighbor, writes back inserts and removes. Depends on npt_pkg.
module npt_ctrl
  import npt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH,
  localparam int AW         = $clog2(TABLE_DEPTH),
  localparam int EW         = 1 + ID_WIDTH + 2 * COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // request side
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic [PID_W-1:0]           point_id,
  input  logic signed [PCOORD_W-1:0] x_coord,
  input  logic signed [PCOORD_W-1:0] y_coord,
  input  logic [DIR_W-1:0]           direction,
  // result handoff
  output logic                       res_valid,
  input  logic                       res_take,
  output npt_result_t                res,
  // table memory
  output logic                       mem_wr_en,
  output logic [AW-1:0]              mem_wr_addr,
  output logic [EW-1:0]              mem_wr_data,
  output logic                       mem_rd_en,
  output logic [AW-1:0]              mem_rd_addr,
  input  logic [EW-1:0]              mem_rd_data
);

  localparam int CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
  localparam logic [AW-1:0]    IDX_LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  state_t state;

  // captured request
  logic [OPCODE_W-1:0]          op_q;
  logic [ID_WIDTH-1:0]          id_q;
  logic signed [COORD_WIDTH-1:0] x_q;
  logic signed [COORD_WIDTH-1:0] y_q;
  logic [DIR_W-1:0]             dir_q;

  // scan bookkeeping
  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [AW-1:0]    ridx;
  logic             pass2;

  // first-pass findings
  logic                          have_id;
  logic [AW-1:0]                 id_idx;
  logic signed [COORD_WIDTH-1:0] id_x;
  logic signed [COORD_WIDTH-1:0] id_y;
  logic                          have_pos;
  logic [ID_WIDTH-1:0]           pos_id;
  logic                          have_free;
  logic [AW-1:0]                 free_idx;

  // second-pass findings
  logic                          have_best;
  logic signed [COORD_WIDTH-1:0] best_c;
  logic [ID_WIDTH-1:0]           best_id;

  // entry fields of the data coming back from memory
  logic                          e_valid;
  logic [ID_WIDTH-1:0]           e_id;
  logic signed [COORD_WIDTH-1:0] e_x;
  logic signed [COORD_WIDTH-1:0] e_y;
  logic                          id_hit;
  logic                          pos_hit;
  logic                          near_hit;

  // result decode at the end of a sweep
  npt_result_t res_next;
  logic        rescan;

  logic accept;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  assign e_valid = mem_rd_data[EW-1];
  assign e_id    = mem_rd_data[EW-2 -: ID_WIDTH];
  assign e_x     = $signed(mem_rd_data[2*COORD_WIDTH-1 -: COORD_WIDTH]);
  assign e_y     = $signed(mem_rd_data[COORD_WIDTH-1:0]);

  // memory read issue
  assign mem_rd_en   = (state == S_SCAN) && (cnt != CNT_END);
  assign mem_rd_addr = cnt[AW-1:0];

  // entry compares
  always_comb begin
    id_hit   = e_valid && (e_id == id_q);
    pos_hit  = e_valid && (e_x == x_q) && (e_y == y_q);
    near_hit = 1'b0;
    unique case (dir_q)
      DIR_NORTH: near_hit = (e_x == id_x) && (e_y > id_y) && (!have_best || e_y < best_c);
      DIR_SOUTH: near_hit = (e_x == id_x) && (e_y < id_y) && (!have_best || e_y > best_c);
      DIR_EAST:  near_hit = (e_y == id_y) && (e_x > id_x) && (!have_best || e_x < best_c);
      DIR_WEST:  near_hit = (e_y == id_y) && (e_x < id_x) && (!have_best || e_x > best_c);
      default:   near_hit = 1'b0;
    endcase
    near_hit = near_hit && e_valid && (ridx != id_idx);
  end

  // write-back: clearing pass, insert into lowest free entry, remove.
  // Writes only happen outside the scan, so a read never overlaps a write.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt[AW-1:0];
    mem_wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      S_FINISH: begin
        if (op_q == OP_INSERT && !have_id && !have_pos && have_free) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = free_idx;
          mem_wr_data = {1'b1, id_q, x_q, y_q};
        end else if (op_q == OP_REMOVE && have_id) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = id_idx;
          mem_wr_data = {1'b0, id_q, id_x, id_y};
        end
      end
      default: ;
    endcase
  end

  // result and second-sweep decision from the sweep findings
  always_comb begin
    res_next = '0;
    rescan   = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (have_id) begin
          res_next.status = ST_EXISTS;
        end else if (have_pos) begin
          res_next.status = ST_OCCUPIED;
        end else if (!have_free) begin
          res_next.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (!have_id) begin
          res_next.status = ST_MISSING;
        end
      end
      OP_POSITION: begin
        if (!have_id) begin
          res_next.status = ST_MISSING;
        end else begin
          res_next.result_x = PCOORD_W'(id_x);
          res_next.result_y = PCOORD_W'(id_y);
        end
      end
      OP_PROBE: begin
        if (have_pos) begin
          res_next.found     = 1'b1;
          res_next.result_id = PID_W'(pos_id);
        end
      end
      OP_NEAREST: begin
        if (!have_id) begin
          res_next.status = ST_MISSING;
        end else if (!pass2) begin
          // second sweep for the neighbor, self excluded
          rescan = 1'b1;
        end else if (!have_best) begin
          res_next.status = ST_NONE;
        end else begin
          res_next.result_id = PID_W'(best_id);
        end
      end
      default: ;
    endcase
  end

  // sequencer state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= mem_rd_en;
      ridx   <= mem_rd_addr;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[AW-1:0] == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q      <= opcode;
            id_q      <= ID_WIDTH'(point_id);
            x_q       <= COORD_WIDTH'(x_coord);
            y_q       <= COORD_WIDTH'(y_coord);
            dir_q     <= direction;
            cnt       <= '0;
            pass2     <= 1'b0;
            have_id   <= 1'b0;
            have_pos  <= 1'b0;
            have_free <= 1'b0;
            have_best <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_rd_en) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_vld) begin
            if (!pass2) begin
              if (id_hit && !have_id) begin
                have_id <= 1'b1;
                id_idx  <= ridx;
                id_x    <= e_x;
                id_y    <= e_y;
              end
              if (pos_hit && !have_pos) begin
                have_pos <= 1'b1;
                pos_id   <= e_id;
              end
              if (!e_valid && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= ridx;
              end
            end else if (near_hit) begin
              have_best <= 1'b1;
              best_id   <= e_id;
              best_c    <= (dir_q == DIR_NORTH || dir_q == DIR_SOUTH) ? e_y : e_x;
            end
            if (ridx == IDX_LAST) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (rescan) begin
            pass2 <= 1'b1;
            cnt   <= '0;
            state <= S_SCAN;
          end else begin
            res   <= res_next;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/npt_scoreboard_pkg.sv
// Scoreboard for the nearest-point table testbench: a shadow copy of the point table
// that predicts one result per accepted request and checks results in order.
// Depends on npt_pkg for field widths, opcodes, directions and status codes.
package npt_scoreboard_pkg;
  import npt_pkg::*;

  class point_table_scoreboard;
    // Shadow table, same slot order as the hardware (lowest free slot first)
    bit                         live [DEF_TABLE_DEPTH];
    logic [PID_W-1:0]           ids  [DEF_TABLE_DEPTH];
    logic signed [PCOORD_W-1:0] xs   [DEF_TABLE_DEPTH];
    logic signed [PCOORD_W-1:0] ys   [DEF_TABLE_DEPTH];
    int                         occupancy;
    int                         mismatches;
    int                         results_seen;
    npt_result_t                expected_q[$];

    function new();
      foreach (live[i]) live[i] = 1'b0;
      occupancy    = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int slot_of_id(logic [PID_W-1:0] pid);
      int i;
      for (i = 0; i < DEF_TABLE_DEPTH; i++)
        if (live[i] && ids[i] == pid) return i;
      return -1;
    endfunction

    function int slot_of_pos(logic signed [PCOORD_W-1:0] px, logic signed [PCOORD_W-1:0] py);
      int i;
      for (i = 0; i < DEF_TABLE_DEPTH; i++)
        if (live[i] && xs[i] == px && ys[i] == py) return i;
      return -1;
    endfunction

    // Closest point in the same column (north/south) or row (east/west)
    function int neighbor_slot(int self, logic [DIR_W-1:0] dir);
      int  i;
      int  best;
      bit  hit;
      best = -1;
      for (i = 0; i < DEF_TABLE_DEPTH; i++) begin
        if (!live[i] || i == self) continue;
        case (dir)
          DIR_NORTH: hit = xs[i] == xs[self] && ys[i] > ys[self] &&
                           (best < 0 || ys[i] < ys[best]);
          DIR_SOUTH: hit = xs[i] == xs[self] && ys[i] < ys[self] &&
                           (best < 0 || ys[i] > ys[best]);
          DIR_EAST:  hit = ys[i] == ys[self] && xs[i] > xs[self] &&
                           (best < 0 || xs[i] < xs[best]);
          default:   hit = ys[i] == ys[self] && xs[i] < xs[self] &&
                           (best < 0 || xs[i] > xs[best]);
        endcase
        if (hit) best = i;
      end
      return best;
    endfunction

    // Random occupied slot, or -1 when the table is empty
    function int pick_live_slot();
      int start;
      int i;
      int k;
      if (occupancy == 0) return -1;
      start = $urandom_range(0, DEF_TABLE_DEPTH - 1);
      for (i = 0; i < DEF_TABLE_DEPTH; i++) begin
        k = (start + i) % DEF_TABLE_DEPTH;
        if (live[k]) return k;
      end
      return -1;
    endfunction

    // Accepted request: update the shadow table and queue the expected result
    function void note_request(logic [OPCODE_W-1:0] op, logic [PID_W-1:0] pid,
                               logic signed [PCOORD_W-1:0] px,
                               logic signed [PCOORD_W-1:0] py, logic [DIR_W-1:0] dir);
      npt_result_t r;
      int          k;
      int          j;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          // id clash wins over position clash, which wins over a full table
          if (slot_of_id(pid) >= 0) begin
            r.status = ST_EXISTS;
          end else if (slot_of_pos(px, py) >= 0) begin
            r.status = ST_OCCUPIED;
          end else begin
            k = -1;
            for (j = DEF_TABLE_DEPTH - 1; j >= 0; j--)
              if (!live[j]) k = j;
            if (k < 0) begin
              r.status = ST_FULL;
            end else begin
              live[k] = 1'b1;
              ids[k]  = pid;
              xs[k]   = px;
              ys[k]   = py;
              occupancy++;
            end
          end
        end
        OP_REMOVE: begin
          k = slot_of_id(pid);
          if (k < 0) begin
            r.status = ST_MISSING;
          end else begin
            live[k] = 1'b0;
            occupancy--;
          end
        end
        OP_POSITION: begin
          k = slot_of_id(pid);
          if (k < 0) begin
            r.status = ST_MISSING;
          end else begin
            r.result_x = xs[k];
            r.result_y = ys[k];
          end
        end
        OP_PROBE: begin
          k = slot_of_pos(px, py);
          if (k >= 0) begin
            r.found     = 1'b1;
            r.result_id = ids[k];
          end
        end
        OP_NEAREST: begin
          k = slot_of_id(pid);
          if (k < 0) begin
            r.status = ST_MISSING;
          end else begin
            j = neighbor_slot(k, dir);
            if (j < 0) r.status = ST_NONE;
            else r.result_id = ids[j];
          end
        end
        default: ;  // unused opcodes answer all zero
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(npt_result_t got);
      npt_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", results_seen));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         results_seen, got.status, want.status));
      if (got.found !== want.found)
        report($sformatf("result %0d: found %0b, expected %0b",
                         results_seen, got.found, want.found));
      if (got.result_id !== want.result_id)
        report($sformatf("result %0d: result_id %0d, expected %0d",
                         results_seen, got.result_id, want.result_id));
      if (got.result_x !== want.result_x)
        report($sformatf("result %0d: result_x %0d, expected %0d",
                         results_seen, got.result_x, want.result_x));
      if (got.result_y !== want.result_y)
        report($sformatf("result %0d: result_y %0d, expected %0d",
                         results_seen, got.result_y, want.result_y));
    endtask
  endclass

endpackage

>>> tb/axis_nearest_point_table_test.sv
// Top-level testbench for axis_nearest_point_table: directed and random requests
// with random idling on both channels, checked against the scoreboard's shadow table.
// Depends on npt_pkg, npt_scoreboard_pkg and the block's RTL.
module axis_nearest_point_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import npt_pkg::*;
  import npt_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 800;
  localparam int TAIL_CYCLES  = 2 * DEF_TABLE_DEPTH + 16;
  localparam int ID_POOL_SIZE = 96;
  localparam int COORD_POOL   = 9;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode    = '0;
  logic [PID_W-1:0]           point_id  = '0;
  logic signed [PCOORD_W-1:0] x_coord   = '0;
  logic signed [PCOORD_W-1:0] y_coord   = '0;
  logic [DIR_W-1:0]           direction = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic [PID_W-1:0]           result_id;
  logic signed [PCOORD_W-1:0] result_x;
  logic signed [PCOORD_W-1:0] result_y;

  int tx_idle_pct   = 6;
  int rx_idle_pct   = 84;
  int hold_left     = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int cycle_count   = 0;
  int items_sent    = 0;

  logic [PID_W-1:0]           id_pool    [ID_POOL_SIZE];
  logic signed [PCOORD_W-1:0] coord_pool [COORD_POOL];

  point_table_scoreboard sb;

  axis_nearest_point_table u_top (.*);

  initial forever #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, started on request and counted down here
  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: check accepted results, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({status, found, result_id, result_x, result_y});
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Offer one request and wait until it is taken; valid stays high for a back-to-back one
  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [PID_W-1:0] pid,
                          input logic signed [PCOORD_W-1:0] px,
                          input logic signed [PCOORD_W-1:0] py, input logic [DIR_W-1:0] dir);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    point_id  <= pid;
    x_coord   <= px;
    y_coord   <= py;
    direction <= dir;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, pid, px, py, dir);
    items_sent++;
  endtask

  // Sender pause until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic signed [PCOORD_W-1:0] pick_coord();
    if ($urandom_range(0, 99) < 85) return coord_pool[$urandom_range(0, COORD_POOL - 1)];
    return PCOORD_W'($urandom_range(0, 65535));
  endfunction

  // Extremes of every field, each operation and every refusal but a full table, on a fresh table
  task automatic directed_requests();
    // empty table: probe miss and unknown ids
    send_req(OP_PROBE,    16'($urandom), 16'sd0, 16'sd0, DIR_W'($urandom));
    send_req(OP_POSITION, 16'd5, 16'($urandom), 16'($urandom), DIR_W'($urandom));
    send_req(OP_REMOVE,   16'd5, 16'($urandom), 16'($urandom), DIR_W'($urandom));
    send_req(OP_NEAREST,  16'd5, 16'($urandom), 16'($urandom), DIR_NORTH);
    // corners, a center point and neighbors around it
    send_req(OP_INSERT, 16'h0000, -16'sd32768, -16'sd32768, DIR_W'($urandom));
    send_req(OP_INSERT, 16'hFFFF, 16'sd32767, 16'sd32767, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd100, 16'sd0, 16'sd0, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd101, 16'sd0, 16'sd5, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd102, 16'sd0, 16'sd32767, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd103, 16'sd0, -16'sd32768, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd104, 16'sd7, 16'sd0, DIR_W'($urandom));
    // refused inserts: id taken, position taken, both taken
    send_req(OP_INSERT, 16'd100, 16'sd3, 16'sd3, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd106, 16'sd0, 16'sd5, DIR_W'($urandom));
    send_req(OP_INSERT, 16'd100, 16'sd0, 16'sd5, DIR_W'($urandom));
    // all four directions from the center, none to the west, none above the top
    send_req(OP_NEAREST, 16'd100, 16'($urandom), 16'($urandom), DIR_NORTH);
    send_req(OP_NEAREST, 16'd100, 16'($urandom), 16'($urandom), DIR_SOUTH);
    send_req(OP_NEAREST, 16'd100, 16'($urandom), 16'($urandom), DIR_EAST);
    send_req(OP_NEAREST, 16'd100, 16'($urandom), 16'($urandom), DIR_WEST);
    send_req(OP_NEAREST, 16'd102, 16'($urandom), 16'($urandom), DIR_NORTH);
    send_req(OP_PROBE, 16'($urandom), 16'sd0, 16'sd5, DIR_W'($urandom));
    send_req(OP_PROBE, 16'($urandom), -16'sd32768, -16'sd32768, DIR_W'($urandom));
    send_req(OP_POSITION, 16'hFFFF, 16'($urandom), 16'($urandom), DIR_W'($urandom));
    // removing the near neighbor exposes the far one
    send_req(OP_REMOVE,  16'd101, 16'($urandom), 16'($urandom), DIR_W'($urandom));
    send_req(OP_NEAREST, 16'd100, 16'($urandom), 16'($urandom), DIR_NORTH);
    // unused opcodes
    for (int k = 1; k <= 3; k++)
      send_req(OP_NEAREST + OPCODE_W'(k), 16'($urandom), 16'($urandom), 16'($urandom),
               DIR_W'($urandom));
  endtask

  // Fill every slot, then hit the full table with each kind of insert
  task automatic fill_table();
    int k;
    while (sb.occupancy < DEF_TABLE_DEPTH)
      send_req(OP_INSERT, 16'($urandom), pick_coord(), 16'($urandom), DIR_W'($urandom));
    send_req(OP_INSERT, 16'($urandom), 16'($urandom), 16'($urandom), DIR_W'($urandom));
    k = sb.pick_live_slot();
    send_req(OP_INSERT, sb.ids[k], 16'($urandom), 16'($urandom), DIR_W'($urandom));
    k = sb.pick_live_slot();
    send_req(OP_INSERT, 16'($urandom), sb.xs[k], sb.ys[k], DIR_W'($urandom));
  endtask

  // Mixed traffic on a small grid so rows and columns are shared
  task automatic random_request(input int insert_pct);
    logic [OPCODE_W-1:0]        op;
    logic [PID_W-1:0]           pid;
    logic signed [PCOORD_W-1:0] px;
    logic signed [PCOORD_W-1:0] py;
    logic [DIR_W-1:0]           dir;
    int                         r;
    int                         k;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      op = OP_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 22) op = OP_REMOVE;
      else if (r < 42) op = OP_POSITION;
      else if (r < 62) op = OP_PROBE;
      else if (r < 97) op = OP_NEAREST;
      else op = OP_NEAREST + OPCODE_W'($urandom_range(1, 3));
    end
    pid = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    px  = pick_coord();
    py  = pick_coord();
    dir = DIR_W'($urandom_range(0, 3));
    // mostly aim lookups at points that are present
    k = sb.pick_live_slot();
    if (k >= 0 && $urandom_range(0, 9) < 8) begin
      if (op == OP_PROBE) begin
        px = sb.xs[k];
        py = sb.ys[k];
      end else if (op != OP_INSERT) begin
        pid = sb.ids[k];
      end
    end
    send_req(op, pid, px, py, dir);
  endtask

  initial begin
    int base;
    sb = new();
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    coord_pool[0] = -16'sd32768;
    coord_pool[1] = 16'sd32767;
    coord_pool[2] = 16'sd0;
    coord_pool[3] = -16'sd1;
    coord_pool[4] = 16'sd1;
    for (int i = 5; i < COORD_POOL; i++) coord_pool[i] = 16'($urandom);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender busy, receiver mostly stalled
    directed_requests();
    base = items_sent;
    fill_table();
    while (items_sent - base < PHASE_ITEMS) random_request(35);
    drain_results();

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 84;
    rx_idle_pct <= 6;
    base = items_sent;
    while (items_sent - base < PHASE_ITEMS) random_request(30);
    drain_results();

    // no idling, opened by a long receiver hold-off so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_requests++;
    base = items_sent;
    fill_table();
    while (items_sent - base < PHASE_ITEMS) random_request(40);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
